// ----- rtl/lrgo_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package lrgo_pkg;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   localparam logic POLICY_FIRST = 1'b0;
   localparam logic POLICY_BEST  = 1'b1;

   localparam logic [1:0] STAT_OK   = 2'd0;
   localparam logic [1:0] STAT_FULL = 2'd1;
   localparam logic [1:0] STAT_OVFL = 2'd2;

   localparam int SIZE_BITS  = 33;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ALIGN,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic rotate;
      logic insert;
      logic clear;
   } cell_ctrl_type;

endpackage
`default_nettype wire

// ----- rtl/lrgo_align.sv -----
`timescale 1ns / 1ps
`default_nettype none
module lrgo_align import lrgo_pkg::*; #(
   parameter int ALIGN_BYTES = 64
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [31:0]          size_in,
   output logic                      done,
   output logic [SIZE_BITS-1:0]      aligned
);
   // quotient by the alignment as (x * RECIP) >> SHIFT, exact for every x below 2^SIZE_BITS
   localparam int SHIFT = SIZE_BITS + $clog2(ALIGN_BYTES);
   localparam int RB    = SIZE_BITS + 1;
   localparam int HB    = RB / 2;
   localparam int LB    = SIZE_BITS + HB;
   localparam int UB    = SIZE_BITS + RB - HB;
   localparam int PB    = SIZE_BITS + RB;
   localparam logic [79:0] NUMER      = 80'(1) << SHIFT;
   localparam logic [79:0] RECIP_WIDE = (NUMER + 80'(ALIGN_BYTES - 1)) / 80'(ALIGN_BYTES);
   localparam logic [RB-1:0]    RECIP    = RECIP_WIDE[RB-1:0];
   localparam logic [HB-1:0]    RECIP_LO = RECIP[HB-1:0];
   localparam logic [RB-HB-1:0] RECIP_HI = RECIP[RB-1:HB];

   logic [SIZE_BITS-1:0] x_ff, x_in, q_ff, q_in, aligned_ff, aligned_in;
   logic [LB-1:0]        lo_ff, lo_in;
   logic [UB-1:0]        hi_ff, hi_in;
   logic [PB-1:0]        prod;
   logic [2:0]           stage_ff, stage_in;
   logic                 done_ff, done_in;

   // split the multiply in two halves, then shift, then scale back up
   always_comb begin
      x_in       = x_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      q_in       = q_ff;
      aligned_in = aligned_ff;
      done_in    = done_ff;
      stage_in   = {stage_ff[1:0], start};
      prod       = PB'(lo_ff) + (PB'(hi_ff) << HB);
      if (start) begin
         x_in    = SIZE_BITS'(size_in) + SIZE_BITS'(ALIGN_BYTES - 1);
         done_in = 1'b0;
      end
      if (stage_ff[0]) begin
         lo_in = LB'(x_ff) * LB'(RECIP_LO);
         hi_in = UB'(x_ff) * UB'(RECIP_HI);
      end
      if (stage_ff[1]) begin
         q_in = SIZE_BITS'(prod >> SHIFT);
      end
      if (stage_ff[2]) begin
         aligned_in = q_ff * SIZE_BITS'(ALIGN_BYTES);
         done_in    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      x_ff       <= x_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      q_ff       <= q_in;
      aligned_ff <= aligned_in;
      if (reset) begin
         stage_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         stage_ff <= stage_in;
         done_ff  <= done_in;
      end
   end

   assign done    = done_ff;
   assign aligned = aligned_ff;
endmodule
`default_nettype wire

// ----- rtl/lrgo_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
module lrgo_cell import lrgo_pkg::*; #(
   parameter int OFFSET_BITS = 40,
   parameter int IW = 6
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire cell_ctrl_type           ctrl,
   input  wire logic [OFFSET_BITS:0]    new_offset,
   input  wire logic [SIZE_BITS-1:0]    new_size,
   input  wire logic [IW-1:0]           new_slot,
   input  wire logic                    left_valid,
   input  wire logic [OFFSET_BITS:0]    left_offset,
   input  wire logic [SIZE_BITS-1:0]    left_size,
   input  wire logic [IW-1:0]           left_slot,
   input  wire logic                    left_go,
   input  wire logic                    right_valid,
   input  wire logic [OFFSET_BITS:0]    right_offset,
   input  wire logic [SIZE_BITS-1:0]    right_size,
   input  wire logic [IW-1:0]           right_slot,
   output logic                         cell_valid,
   output logic [OFFSET_BITS:0]         cell_offset,
   output logic [SIZE_BITS-1:0]         cell_size,
   output logic [IW-1:0]                cell_slot,
   output logic                         go
);
   logic                 valid_ff, valid_in;
   logic [OFFSET_BITS:0] offset_ff, offset_in;
   logic [SIZE_BITS-1:0] size_ff, size_in;
   logic [IW-1:0]        slot_ff, slot_in;

   // entries sit in ascending offset order; everything above the new one moves right
   assign go = !valid_ff || (offset_ff > new_offset);

   always_comb begin
      valid_in  = valid_ff;
      offset_in = offset_ff;
      size_in   = size_ff;
      slot_in   = slot_ff;
      if (ctrl.clear) begin
         valid_in = 1'b0;
      end else if (ctrl.rotate) begin
         valid_in  = right_valid;
         offset_in = right_offset;
         size_in   = right_size;
         slot_in   = right_slot;
      end else if (ctrl.insert && go) begin
         if (left_go) begin
            valid_in  = left_valid;
            offset_in = left_offset;
            size_in   = left_size;
            slot_in   = left_slot;
         end else begin
            valid_in  = 1'b1;
            offset_in = new_offset;
            size_in   = new_size;
            slot_in   = new_slot;
         end
      end
   end

   always_ff @(posedge clock) begin
      offset_ff <= offset_in;
      size_ff   <= size_in;
      slot_ff   <= slot_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign cell_valid  = valid_ff;
   assign cell_offset = offset_ff;
   assign cell_size   = size_ff;
   assign cell_slot   = slot_ff;
endmodule
`default_nettype wire

// ----- rtl/live_range_gap_offset_allocator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Buffer offset allocator. Placed buffers live in a chain of MAX_ENTRIES cells kept
// in ascending offset order. An allocate word first rounds its size up to
// ALIGN_BYTES with a reciprocal multiply, then rotates the whole chain once past a
// gap scanner, then stores the entry if it was placed and issues the response; the
// next request word can be taken once the response appears. A clear word goes
// straight to the final step. A stalled response holds the next word in its final
// step until the response is taken. csr_wr_data picks first fit (0) or best fit (1,
// reset value). A response waits in its output register while the next request
// word is taken.
module live_range_gap_offset_allocator import lrgo_pkg::*; #(
   parameter int MAX_ENTRIES = 64,
   parameter int ALIGN_BYTES = 64,
   parameter int OFFSET_BITS = 40
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_wr_en,
   input  wire logic                    csr_wr_data,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic                    req_operation,
   input  wire logic [31:0]             req_request_size,
   input  wire logic [63:0]             req_overlap_mask,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic [OFFSET_BITS-1:0]       rsp_placed_offset,
   output logic [SIZE_BITS-1:0]         rsp_rounded_size,
   output logic [5:0]                   rsp_entry_index,
   output logic [1:0]                   rsp_status
);
   localparam int IW = $clog2(MAX_ENTRIES);
   localparam int OW = OFFSET_BITS + 1;
   localparam int SW = (OW > SIZE_BITS ? OW : SIZE_BITS) + 1;
   localparam logic [SW-1:0] SPACE_END = SW'(1) << OFFSET_BITS;

   state_type state_ff, state_in;

   logic                   policy_ff;
   logic                   op_ff, op_in;
   logic [MAX_ENTRIES-1:0] mask_ff, mask_in;
   logic [MAX_ENTRIES-1:0] slot_valid_ff, slot_valid_in;
   logic [IW-1:0]          rot_ff, rot_in;
   logic [OW-1:0]          prev_ff, prev_in, best_off_ff, best_off_in, min_gap_ff, min_gap_in;
   logic                   found_ff, found_in, stop_ff, stop_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [OFFSET_BITS-1:0] rsp_off_ff, rsp_off_in;
   logic [SIZE_BITS-1:0]   rsp_size_ff, rsp_size_in;
   logic [5:0]             rsp_idx_ff, rsp_idx_in;
   logic [1:0]             rsp_stat_ff, rsp_stat_in;

   logic                   accept, align_start, align_done, rsp_free;
   logic [SIZE_BITS-1:0]   aligned;
   cell_ctrl_type          ctrl;

   logic                   cv [MAX_ENTRIES];
   logic [OW-1:0]          co [MAX_ENTRIES];
   logic [SIZE_BITS-1:0]   cs [MAX_ENTRIES];
   logic [IW-1:0]          cx [MAX_ENTRIES];
   logic                   cg [MAX_ENTRIES];

   logic [IW-1:0]          free_slot;
   logic                   table_full;
   logic                   head_hit, fits, over;
   logic [SW-1:0]          off_x, prev_x, gap_x, need_x, end_x;
   logic [OW-1:0]          fin_off;
   logic [1:0]             fin_stat;

   lrgo_align #(.ALIGN_BYTES(ALIGN_BYTES)) u_align (
      .clock   (clock),
      .reset   (reset),
      .start   (align_start),
      .size_in (req_request_size),
      .done    (align_done),
      .aligned (aligned)
   );

   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      localparam int L = (i == 0) ? 0 : i - 1;
      localparam int R = (i == MAX_ENTRIES - 1) ? 0 : i + 1;
      lrgo_cell #(.OFFSET_BITS(OFFSET_BITS), .IW(IW)) u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (ctrl),
         .new_offset   (fin_off),
         .new_size     (aligned),
         .new_slot     (free_slot),
         .left_valid   (cv[L]),
         .left_offset  (co[L]),
         .left_size    (cs[L]),
         .left_slot    (cx[L]),
         .left_go      ((i == 0) ? 1'b0 : cg[L]),
         .right_valid  (cv[R]),
         .right_offset (co[R]),
         .right_size   (cs[R]),
         .right_slot   (cx[R]),
         .cell_valid   (cv[i]),
         .cell_offset  (co[i]),
         .cell_size    (cs[i]),
         .cell_slot    (cx[i]),
         .go           (cg[i])
      );
   end

   always_comb begin
      free_slot = '0;
      for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
         if (!slot_valid_ff[i]) begin
            free_slot = IW'(i);
         end
      end
   end
   assign table_full = &slot_valid_ff;

   // gap scanner works on the head cell while the chain rotates
   assign off_x    = SW'(co[0]);
   assign prev_x   = SW'(prev_ff);
   assign gap_x    = off_x - prev_x;
   assign need_x   = SW'(aligned);
   assign end_x    = off_x + SW'(cs[0]);
   assign head_hit = cv[0] && mask_ff[cx[0]] && !stop_ff;
   assign fits     = (off_x >= prev_x) && (need_x <= gap_x)
                     && (!found_ff || (gap_x < SW'(min_gap_ff)));

   assign fin_off  = found_ff ? best_off_ff : prev_ff;
   assign over     = (SW'(fin_off) + need_x) > SPACE_END;
   assign fin_stat = table_full ? STAT_FULL : (over ? STAT_OVFL : STAT_OK);

   assign accept      = req_valid && req_ready;
   assign align_start = accept && (req_operation == OP_ALLOC);
   assign rsp_free    = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      mask_in       = mask_ff;
      slot_valid_in = slot_valid_ff;
      rot_in        = rot_ff;
      prev_in       = prev_ff;
      best_off_in   = best_off_ff;
      min_gap_in    = min_gap_ff;
      found_in      = found_ff;
      stop_in       = stop_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_off_in    = rsp_off_ff;
      rsp_size_in   = rsp_size_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_stat_in   = rsp_stat_ff;
      ctrl          = '0;
      req_ready     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in       = req_operation;
               mask_in     = req_overlap_mask[MAX_ENTRIES-1:0];
               rot_in      = '0;
               prev_in     = '0;
               best_off_in = '0;
               min_gap_in  = '0;
               found_in    = 1'b0;
               stop_in     = 1'b0;
               state_in    = (req_operation == OP_CLEAR) ? ST_FINISH : ST_ALIGN;
            end
         end
         ST_ALIGN: begin
            if (align_done) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            ctrl.rotate = 1'b1;
            if (head_hit) begin
               if (fits) begin
                  best_off_in = prev_ff;
                  min_gap_in  = gap_x[OW-1:0];
                  found_in    = 1'b1;
                  stop_in     = (policy_ff == POLICY_FIRST);
               end
               if (end_x > prev_x) begin
                  prev_in = end_x[OW-1:0];
               end
            end
            rot_in = rot_ff + 1'b1;
            if (rot_ff == IW'(MAX_ENTRIES - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (op_ff == OP_CLEAR) begin
                  ctrl.clear    = 1'b1;
                  slot_valid_in = '0;
                  rsp_off_in    = '0;
                  rsp_size_in   = '0;
                  rsp_idx_in    = '0;
                  rsp_stat_in   = STAT_OK;
               end else begin
                  rsp_size_in = aligned;
                  rsp_stat_in = fin_stat;
                  rsp_off_in  = '0;
                  rsp_idx_in  = '0;
                  if (fin_stat == STAT_OK) begin
                     ctrl.insert              = 1'b1;
                     slot_valid_in[free_slot] = 1'b1;
                     rsp_off_in               = fin_off[OFFSET_BITS-1:0];
                     rsp_idx_in               = 6'(free_slot);
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      mask_ff     <= mask_in;
      rot_ff      <= rot_in;
      prev_ff     <= prev_in;
      best_off_ff <= best_off_in;
      min_gap_ff  <= min_gap_in;
      found_ff    <= found_in;
      stop_ff     <= stop_in;
      rsp_off_ff  <= rsp_off_in;
      rsp_size_ff <= rsp_size_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_stat_ff <= rsp_stat_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         slot_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         policy_ff     <= POLICY_BEST;
      end else begin
         state_ff      <= state_in;
         slot_valid_ff <= slot_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr_en) begin
            policy_ff <= csr_wr_data;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_placed_offset = rsp_off_ff;
   assign rsp_rounded_size  = rsp_size_ff;
   assign rsp_entry_index   = rsp_idx_ff;
   assign rsp_status        = rsp_stat_ff;
endmodule
`default_nettype wire

// ----- rtl/lrgo_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module lrgo_checker import lrgo_pkg::*; #(
   parameter int OFFSET_BITS = 40
) (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_valid,
   input wire logic                   req_ready,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_ready,
   input wire logic [OFFSET_BITS-1:0] rsp_placed_offset,
   input wire logic [SIZE_BITS-1:0]   rsp_rounded_size,
   input wire logic [5:0]             rsp_entry_index,
   input wire logic [1:0]             rsp_status
);
   // a waiting response word holds still
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_placed_offset)
         && $stable(rsp_rounded_size) && $stable(rsp_status) && $stable(rsp_entry_index))
      else $error("response word changed while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STAT_OK) || (rsp_status == STAT_FULL)
         || (rsp_status == STAT_OVFL))
      else $error("undefined status code");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STAT_OK) |-> (rsp_placed_offset == '0)
         && (rsp_entry_index == '0))
      else $error("failed allocation reports an offset or slot");

   // one request word at a time
   a_one_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");
endmodule

bind live_range_gap_offset_allocator lrgo_checker #(.OFFSET_BITS(OFFSET_BITS)) u_chk (.*);
`default_nettype wire
